[design/csma_ca_ack_retry_controller_macros.svh]
// Assertion helpers used by the checker file
`ifndef CSMA_CA_ACK_RETRY_CONTROLLER_MACROS_SVH
`define CSMA_CA_ACK_RETRY_CONTROLLER_MACROS_SVH

// Check a consequence in the cycle after the antecedent
`define CAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cac assertion failed");

// Check a consequence in the same cycle as the antecedent
`define CAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cac assertion failed");

`endif

[design/cac_pkg.sv]
package cac_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [6:0]  SIFS_MAX_PHY_LEN = 7'd18;

    localparam logic [15:0] RST_UNIT_BACKOFF = 16'd320;
    localparam logic [15:0] RST_ACK_WAIT     = 16'd864;
    localparam logic [15:0] RST_SHORT_IFS    = 16'd192;
    localparam logic [15:0] RST_LONG_IFS     = 16'd640;
    localparam logic [2:0]  RST_MIN_EXP      = 3'd3;
    localparam logic [2:0]  RST_MAX_EXP      = 3'd5;
    localparam logic [2:0]  RST_MAX_BACKOFFS = 3'd3;
    localparam logic [2:0]  RST_MAX_TRIES    = 3'd3;

    typedef enum logic [2:0] {
        REG_UNIT_BACKOFF = 3'd0,
        REG_ACK_WAIT     = 3'd1,
        REG_SHORT_IFS    = 3'd2,
        REG_LONG_IFS     = 3'd3,
        REG_MIN_EXP      = 3'd4,
        REG_MAX_EXP      = 3'd5,
        REG_MAX_BACKOFFS = 3'd6,
        REG_MAX_TRIES    = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        MODE_START_SEND      = 4'd0,
        MODE_BACKOFF_EXPIRED = 4'd1,
        MODE_CCA_BUSY        = 4'd2,
        MODE_TX_READY        = 4'd3,
        MODE_TX_END          = 4'd4,
        MODE_RX_OK           = 4'd5,
        MODE_RX_CRC_ERROR    = 4'd6,
        MODE_ACK_TIMEOUT     = 4'd7,
        MODE_STOP            = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_BACKOFF = 3'd1,
        ACT_CCA     = 3'd2,
        ACT_TX      = 3'd3,
        ACT_ACKWAIT = 3'd4,
        ACT_OK      = 3'd5,
        ACT_FAIL    = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SENT     = 2'd1,
        PH_SENT_ACK = 2'd2,
        PH_ACK      = 2'd3
    } phase_t;

    typedef struct packed {
        logic [15:0] unit_backoff_us;
        logic [15:0] ack_wait_us;
        logic [15:0] short_ifs_us;
        logic [15:0] long_ifs_us;
        logic [2:0]  min_exponent;
        logic [2:0]  max_exponent;
        logic [2:0]  max_backoffs;
        logic [2:0]  max_tries;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic        ack_wanted;
        logic [6:0]  frame_length;
        logic [7:0]  frame_seq;
        logic        rx_is_ack;
        logic [6:0]  random_bits;
        logic        in_receive_state;
        logic [31:0] elapsed_us;
        logic        ack_tx_pending;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [22:0] timer_us;
        logic [1:0]  send_status;
    } out_word_t;

endpackage

[design/cac_regs.sv]
module cac_regs
    import cac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_backoff_us <= RST_UNIT_BACKOFF;
            cfg_reg.ack_wait_us     <= RST_ACK_WAIT;
            cfg_reg.short_ifs_us    <= RST_SHORT_IFS;
            cfg_reg.long_ifs_us     <= RST_LONG_IFS;
            cfg_reg.min_exponent    <= RST_MIN_EXP;
            cfg_reg.max_exponent    <= RST_MAX_EXP;
            cfg_reg.max_backoffs    <= RST_MAX_BACKOFFS;
            cfg_reg.max_tries       <= RST_MAX_TRIES;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_UNIT_BACKOFF: cfg_reg.unit_backoff_us <= pwdata[15:0];
                REG_ACK_WAIT:     cfg_reg.ack_wait_us     <= pwdata[15:0];
                REG_SHORT_IFS:    cfg_reg.short_ifs_us    <= pwdata[15:0];
                REG_LONG_IFS:     cfg_reg.long_ifs_us     <= pwdata[15:0];
                REG_MIN_EXP:      cfg_reg.min_exponent    <= pwdata[2:0];
                REG_MAX_EXP:      cfg_reg.max_exponent    <= pwdata[2:0];
                REG_MAX_BACKOFFS: cfg_reg.max_backoffs    <= pwdata[2:0];
                REG_MAX_TRIES:    cfg_reg.max_tries       <= pwdata[2:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_UNIT_BACKOFF: prdata = {16'd0, cfg_reg.unit_backoff_us};
            REG_ACK_WAIT:     prdata = {16'd0, cfg_reg.ack_wait_us};
            REG_SHORT_IFS:    prdata = {16'd0, cfg_reg.short_ifs_us};
            REG_LONG_IFS:     prdata = {16'd0, cfg_reg.long_ifs_us};
            REG_MIN_EXP:      prdata = {29'd0, cfg_reg.min_exponent};
            REG_MAX_EXP:      prdata = {29'd0, cfg_reg.max_exponent};
            REG_MAX_BACKOFFS: prdata = {29'd0, cfg_reg.max_backoffs};
            REG_MAX_TRIES:    prdata = {29'd0, cfg_reg.max_tries};
        endcase
    end

endmodule

[design/csma_ca_ack_retry_controller.sv]
// Latency: a result word appears in the cycle after its event word is accepted.
// Throughput: one event word per cycle unless the output stalls; the output register
// refills as it is taken; the backoff multiply (slots times unit period) sets the path.
// Reset: asynchronous, active low; send phase idle, exponent, counts and spacing
// zero, registers at their defaults; the expected sequence holds until a send starts.
module csma_ca_ack_retry_controller
    import cac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    cac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phase_t      phase_reg, phase_next;
    logic [2:0]  be_reg, be_next;
    logic [2:0]  bc_reg, bc_next;
    logic [2:0]  tc_reg, tc_next;
    logic [15:0] spacing_reg, spacing_next;
    logic [7:0]  seq_reg, seq_next;
    logic        out_valid_reg;
    out_word_t   out_data_reg;
    out_word_t   out_data_next;

    logic        accept;
    logic        sending;
    logic        can_retry;
    logic        ack_match;
    logic        clear_to_cca;
    logic        bo_req;
    logic        restart;
    logic        bo_fail;
    logic [2:0]  bo_be;
    logic [2:0]  bo_bc;
    logic [7:0]  mask;
    logic [7:0]  slots;
    logic [23:0] prod;
    logic [3:0]  be_sum;
    logic [2:0]  be_inc;
    logic [15:0] rx_spacing;
    action_t     act;
    logic [22:0] timer;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sending      = (phase_reg == PH_SENT) || (phase_reg == PH_SENT_ACK);
    assign can_retry    = tc_reg < cfg.max_tries;
    assign ack_match    = (phase_reg == PH_ACK) && in_data.rx_is_ack
                          && (in_data.frame_seq == seq_reg);
    assign clear_to_cca = in_data.in_receive_state
                          && (in_data.elapsed_us >= {16'd0, spacing_reg});
    assign rx_spacing   = (in_data.frame_length <= SIFS_MAX_PHY_LEN) ?
                          cfg.short_ifs_us : cfg.long_ifs_us;

    always_comb
    begin
        bo_req  = 1'b0;
        restart = 1'b0;
        unique case (mode_t'(in_data.mode))
            MODE_START_SEND:
            begin
                bo_req  = (phase_reg == PH_IDLE);
                restart = 1'b1;
            end
            MODE_BACKOFF_EXPIRED: bo_req = sending && !clear_to_cca;
            MODE_CCA_BUSY:        bo_req = sending;
            MODE_TX_READY:        bo_req = sending && in_data.ack_tx_pending;
            MODE_ACK_TIMEOUT:
            begin
                bo_req  = (phase_reg == PH_ACK) && can_retry;
                restart = 1'b1;
            end
            default:
            begin
                bo_req  = 1'b0;
                restart = 1'b0;
            end
        endcase
    end

    assign bo_be   = restart ? cfg.min_exponent : be_reg;
    assign bo_bc   = restart ? 3'd0 : bc_reg;
    assign bo_fail = bo_bc >= cfg.max_backoffs;
    assign mask    = (8'd1 << bo_be) - 8'd1;
    assign slots   = {1'b0, in_data.random_bits & mask[6:0]} + 8'd1;
    assign prod    = 24'(slots) * 24'(cfg.unit_backoff_us);
    assign be_sum  = {1'b0, bo_be} + 4'd1;
    assign be_inc  = (be_sum > {1'b0, cfg.max_exponent}) ? cfg.max_exponent : be_sum[2:0];

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        be_next      = be_reg;
        bc_next      = bc_reg;
        tc_next      = tc_reg;
        spacing_next = spacing_reg;
        seq_next     = seq_reg;
        unique case (mode_t'(in_data.mode))
            MODE_START_SEND:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = in_data.ack_wanted ? PH_SENT_ACK : PH_SENT;
                    seq_next   = in_data.frame_seq;
                    tc_next    = 3'd1;
                end
            end
            MODE_TX_END:
            begin
                if (sending)
                begin
                    spacing_next = rx_spacing;
                    phase_next   = (phase_reg == PH_SENT_ACK) ? PH_ACK : PH_IDLE;
                end
            end
            MODE_RX_OK:
            begin
                spacing_next = rx_spacing;
                if (ack_match)
                begin
                    phase_next = PH_IDLE;
                end
            end
            MODE_RX_CRC_ERROR: spacing_next = cfg.long_ifs_us;
            MODE_ACK_TIMEOUT:
            begin
                if (phase_reg == PH_ACK)
                begin
                    if (can_retry)
                    begin
                        phase_next = PH_SENT_ACK;
                        tc_next    = tc_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            MODE_STOP: phase_next = PH_IDLE;
            default:   phase_next = phase_reg;
        endcase
        if (bo_req)
        begin
            if (bo_fail)
            begin
                be_next    = bo_be;
                bc_next    = bo_bc;
                phase_next = PH_IDLE;
            end
            else
            begin
                be_next = be_inc;
                bc_next = bo_bc + 3'd1;
            end
        end
    end

    // outputs
    always_comb
    begin
        act   = ACT_NONE;
        timer = 23'd0;
        if (bo_req)
        begin
            if (bo_fail)
            begin
                act = ACT_FAIL;
            end
            else
            begin
                act   = ACT_BACKOFF;
                timer = prod[22:0];
            end
        end
        else
        begin
            unique case (mode_t'(in_data.mode))
                MODE_BACKOFF_EXPIRED: act = sending ? ACT_CCA : ACT_NONE;
                MODE_TX_READY:        act = sending ? ACT_TX : ACT_NONE;
                MODE_TX_END:
                begin
                    if (phase_reg == PH_SENT_ACK)
                    begin
                        act   = ACT_ACKWAIT;
                        timer = {7'd0, cfg.ack_wait_us};
                    end
                    else if (phase_reg == PH_SENT)
                    begin
                        act = ACT_OK;
                    end
                end
                MODE_RX_OK:       act = ack_match ? ACT_OK : ACT_NONE;
                MODE_ACK_TIMEOUT: act = (phase_reg == PH_ACK) ? ACT_FAIL : ACT_NONE;
                default:          act = ACT_NONE;
            endcase
        end
        out_data_next.action      = act;
        out_data_next.timer_us    = timer;
        out_data_next.send_status = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            be_reg        <= 3'd0;
            bc_reg        <= 3'd0;
            tc_reg        <= 3'd0;
            spacing_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                be_reg      <= be_next;
                bc_reg      <= bc_next;
                tc_reg      <= tc_next;
                spacing_reg <= spacing_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg      <= seq_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

[design/cac_checker.sv]
`include "csma_ca_ack_retry_controller_macros.svh"

module cac_checker
    import cac_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input out_word_t         out_data
);

    logic stalled;
    logic done;

    assign stalled = out_valid && !out_ready;
    assign done    = out_valid && ((out_data.action == ACT_OK) || (out_data.action == ACT_FAIL));

    `CAC_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid)
    `CAC_ASSERT_NEXT(a_out_stable, clk, rst_n, stalled, $stable(out_data))
    `CAC_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, in_valid && in_ready, out_valid)
    `CAC_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, stalled, !in_ready)
    `CAC_ASSERT_NOW(a_done_goes_idle, clk, rst_n, done, out_data.send_status == PH_IDLE)

endmodule

bind csma_ca_ack_retry_controller cac_checker u_cac_checker (.*);
